@@ src/iesst_pkg.sv @@
// Shared types and codes for the idle escalation state timer.
package iesst_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_INTERACT = 2'd1;
  localparam logic [1:0] CMD_SET      = 2'd2;
  localparam logic [1:0] CMD_TAKE     = 2'd3;

  // State codes with a fixed meaning; the rest are reactions
  localparam logic [2:0] ST_NORMAL   = 3'd0;
  localparam logic [2:0] ST_CURIOUS  = 3'd1;
  localparam logic [2:0] ST_BORED    = 3'd2;
  localparam logic [2:0] ST_SLEEPING = 3'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CURIOUS  = 2'd0;
  localparam logic [1:0] CFG_BORED    = 2'd1;
  localparam logic [1:0] CFG_SLEEPING = 2'd2;

  localparam int unsigned CFG_W = 32;

  localparam logic [CFG_W-1:0] CURIOUS_RST  = 32'd30000;
  localparam logic [CFG_W-1:0] BORED_RST    = 32'd120000;
  localparam logic [CFG_W-1:0] SLEEPING_RST = 32'd600000;

  // Idle thresholds in milliseconds
  typedef struct packed {
    logic [CFG_W-1:0] curious;
    logic [CFG_W-1:0] bored;
    logic [CFG_W-1:0] sleeping;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [2:0] current_state;
    logic [2:0] prior_state;
    logic       changed_flag;
    logic       timed_active;
  } res_t;

  // State view for checking
  typedef struct packed {
    logic timed;
    logic changed;
    logic dl_zero;
  } status_t;

endpackage

@@ src/iesst_cfg.sv @@
// Threshold registers of the idle escalation state timer.
module iesst_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_idx,
  input  logic [iesst_pkg::CFG_W-1:0] cfg_wdata,
  output iesst_pkg::cfg_t             cfg
);

  iesst_pkg::cfg_t cfg_r;

  // Write one threshold; index three is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curious  <= iesst_pkg::CURIOUS_RST;
      cfg_r.bored    <= iesst_pkg::BORED_RST;
      cfg_r.sleeping <= iesst_pkg::SLEEPING_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        iesst_pkg::CFG_CURIOUS:  cfg_r.curious  <= cfg_wdata;
        iesst_pkg::CFG_BORED:    cfg_r.bored    <= cfg_wdata;
        iesst_pkg::CFG_SLEEPING: cfg_r.sleeping <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/iesst_core.sv @@
// Timer state and per-word update logic of the idle escalation state timer.
module iesst_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [1:0]                  cmd,
  input  logic [2:0]                  new_state,
  input  logic [31:0]                 duration_ms,
  input  iesst_pkg::cfg_t             cfg,
  output iesst_pkg::res_t             res,
  output iesst_pkg::status_t          status
);

  // Compare width covers both the time and the thresholds
  localparam int CW = (TIME_BITS > iesst_pkg::CFG_W) ? TIME_BITS : iesst_pkg::CFG_W;

  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] touch_r, touch_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic                 timed_r, timed_nxt;
  logic [2:0]           state_r, state_nxt;
  logic [2:0]           prev_r, prev_nxt;
  logic                 chg_r, chg_nxt;

  logic [TIME_BITS-1:0] now_inc;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] idle_raw;
  logic [CW-1:0]        idle;
  logic [CW-1:0]        dur_ext;
  logic                 sw_en;
  logic [2:0]           sw_code;
  logic                 flag_out;

  // Idle time wraps at the time width before it meets the thresholds
  assign now_inc  = now_r + 1'b1;
  assign diff     = now_inc - dl_r;
  assign idle_raw = now_inc - touch_r;
  assign idle     = CW'(idle_raw);
  assign dur_ext  = CW'(duration_ms);

  // Work out the next state for the word at the head
  always_comb begin
    now_nxt   = now_r;
    touch_nxt = touch_r;
    dl_nxt    = dl_r;
    timed_nxt = timed_r;
    state_nxt = state_r;
    prev_nxt  = prev_r;
    chg_nxt   = chg_r;
    sw_en     = 1'b0;
    sw_code   = iesst_pkg::ST_NORMAL;
    flag_out  = chg_r;

    case (cmd)
      iesst_pkg::CMD_TICK: begin
        now_nxt = now_inc;
        if (timed_r) begin
          // Deadline reached: drop back to normal, keep prior state
          if (!diff[TIME_BITS-1]) begin
            timed_nxt = 1'b0;
            dl_nxt    = '0;
            state_nxt = iesst_pkg::ST_NORMAL;
            chg_nxt   = 1'b1;
          end
        end else if (state_r != iesst_pkg::ST_SLEEPING) begin
          // Escalate by idle time
          if (idle >= CW'(cfg.sleeping)) begin
            sw_en   = 1'b1;
            sw_code = iesst_pkg::ST_SLEEPING;
          end else if (idle >= CW'(cfg.bored)) begin
            sw_en   = 1'b1;
            sw_code = iesst_pkg::ST_BORED;
          end else if (idle >= CW'(cfg.curious)) begin
            sw_en   = 1'b1;
            sw_code = iesst_pkg::ST_CURIOUS;
          end else if (state_r == iesst_pkg::ST_CURIOUS ||
                       state_r == iesst_pkg::ST_BORED) begin
            sw_en   = 1'b1;
            sw_code = iesst_pkg::ST_NORMAL;
          end
        end
      end
      iesst_pkg::CMD_INTERACT: begin
        touch_nxt = now_r;
        if (state_r == iesst_pkg::ST_SLEEPING || state_r == iesst_pkg::ST_CURIOUS ||
            state_r == iesst_pkg::ST_BORED) begin
          sw_en   = 1'b1;
          sw_code = iesst_pkg::ST_NORMAL;
        end
      end
      iesst_pkg::CMD_SET: begin
        sw_en   = 1'b1;
        sw_code = new_state;
        if (duration_ms != '0) begin
          dl_nxt    = now_r + dur_ext[TIME_BITS-1:0];
          timed_nxt = 1'b1;
        end
      end
      default: begin
        chg_nxt = 1'b0;
      end
    endcase

    // Apply a state switch only on a real change
    if (sw_en && sw_code != state_r) begin
      prev_nxt  = state_r;
      state_nxt = sw_code;
      chg_nxt   = 1'b1;
    end

    if (cmd != iesst_pkg::CMD_TAKE) begin
      flag_out = chg_nxt;
    end
  end

  // Hold the timer state, advance on each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      touch_r <= '0;
      dl_r    <= '0;
      timed_r <= 1'b0;
      state_r <= iesst_pkg::ST_NORMAL;
      prev_r  <= iesst_pkg::ST_NORMAL;
      chg_r   <= 1'b1;
    end else if (fire) begin
      now_r   <= now_nxt;
      touch_r <= touch_nxt;
      dl_r    <= dl_nxt;
      timed_r <= timed_nxt;
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      chg_r   <= chg_nxt;
    end
  end

  assign res.current_state = state_nxt;
  assign res.prior_state   = prev_nxt;
  assign res.changed_flag  = flag_out;
  assign res.timed_active  = timed_nxt;

  assign status.timed   = timed_r;
  assign status.changed = chg_r;
  assign status.dl_zero = (dl_r == '0);

endmodule

@@ src/idle_escalation_state_timer_core.sv @@
// Top level of the idle escalation state timer: input and result registers.
//
// Inactivity state machine stepped by one-millisecond tick words. Each input
// word (tick, interaction, set state, take changed flag) yields one result
// word with the current and prior state codes, the changed flag and whether
// a timed state is armed. A word is taken into an input register, evaluated
// against the timer state and written to a result register, so the block
// accepts one word per cycle while out_stall is low; the result register
// holds under out_stall while a further word waits in the input register.
// Time wraps modulo 2^TIME_BITS. Threshold registers may be written only
// while no word is in flight.
module idle_escalation_state_timer_core #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_new_state,
  input  logic [31:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_current_state,
  output logic [2:0]  out_prior_state,
  output logic        out_changed_flag,
  output logic        out_timed_active
);

  iesst_pkg::cfg_t    cfg;
  iesst_pkg::res_t    res;
  iesst_pkg::status_t status;

  logic        in_vld_r;
  logic [1:0]  cmd_r;
  logic [2:0]  ns_r;
  logic [31:0] dur_r;
  logic        out_vld_r;
  iesst_pkg::res_t out_r;
  logic        adv;
  logic        fire;

  // Result register free or draining this cycle
  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  iesst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iesst_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd         (cmd_r),
    .new_state   (ns_r),
    .duration_ms (dur_r),
    .cfg         (cfg),
    .res         (res),
    .status      (status)
  );

  // Input register: load a word whenever not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_r <= in_cmd;
      ns_r  <= in_new_state;
      dur_r <= in_duration_ms;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_current_state = out_r.current_state;
  assign out_prior_state   = out_r.prior_state;
  assign out_changed_flag  = out_r.changed_flag;
  assign out_timed_active  = out_r.timed_active;

  // An evaluated word always lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("evaluated word did not reach the result register");

  // Taking the changed flag clears it
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd_r == iesst_pkg::CMD_TAKE |=> !status.changed)
    else $error("changed flag not cleared by take");

  // A disarmed deadline reads as zero
  a_dl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !status.timed |-> status.dl_zero)
    else $error("deadline nonzero while no timed state is armed");

  // Reported timed bit matches the armed deadline after the update
  a_timed_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_r.timed_active == status.timed)
    else $error("reported timed bit disagrees with deadline state");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the idle escalation state timer core.
`timescale 1ns / 100ps
module tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [2:0]  in_new_state;
  logic [31:0] in_duration_ms;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_current_state;
  logic [2:0]  out_prior_state;
  logic        out_changed_flag;
  logic        out_timed_active;

  idle_escalation_state_timer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_new_state      (in_new_state),
    .in_duration_ms    (in_duration_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_state (out_current_state),
    .out_prior_state   (out_prior_state),
    .out_changed_flag  (out_changed_flag),
    .out_timed_active  (out_timed_active)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predicted timer state and thresholds
  iesst_pkg::cfg_t thr;
  logic [31:0] clock_ms;
  logic [31:0] touch_ms;
  logic [31:0] due_ms;
  logic        due_armed;
  logic        chg;
  logic [2:0]  cur_code;
  logic [2:0]  prev_code;

  iesst_pkg::res_t pending_results[$];

  int unsigned n_words;
  int unsigned n_cmd [4];
  int unsigned n_checked;
  int unsigned n_fail;
  int unsigned n_settings;
  int unsigned stall_left;
  bit          idling;

  // Return the predicted timer to its post-reset state
  function automatic void clear_timer();
    thr.curious  = iesst_pkg::CURIOUS_RST;
    thr.bored    = iesst_pkg::BORED_RST;
    thr.sleeping = iesst_pkg::SLEEPING_RST;
    clock_ms     = '0;
    touch_ms     = '0;
    due_ms       = '0;
    due_armed    = 1'b0;
    cur_code     = iesst_pkg::ST_NORMAL;
    prev_code    = iesst_pkg::ST_NORMAL;
    chg          = 1'b1;
  endfunction

  // Switch state code; an equal code changes nothing
  function automatic void enter_state(logic [2:0] code);
    if (code != cur_code) begin
      prev_code = cur_code;
      cur_code  = code;
      chg       = 1'b1;
    end
  endfunction

  // Advance one millisecond: an armed timed state is handled, else idle escalation
  function automatic void tick_ms();
    logic [31:0] gap;
    logic [31:0] idle;
    clock_ms = clock_ms + 32'd1;
    if (due_armed) begin
      gap = clock_ms - due_ms;
      if (!gap[31]) begin
        due_armed = 1'b0;
        due_ms    = '0;
        cur_code  = iesst_pkg::ST_NORMAL;
        chg       = 1'b1;
      end
    end else if (cur_code != iesst_pkg::ST_SLEEPING) begin
      idle = clock_ms - touch_ms;
      if (idle >= thr.sleeping) begin
        enter_state(iesst_pkg::ST_SLEEPING);
      end else if (idle >= thr.bored) begin
        enter_state(iesst_pkg::ST_BORED);
      end else if (idle >= thr.curious) begin
        enter_state(iesst_pkg::ST_CURIOUS);
      end else if (cur_code == iesst_pkg::ST_CURIOUS ||
                   cur_code == iesst_pkg::ST_BORED) begin
        enter_state(iesst_pkg::ST_NORMAL);
      end
    end
  endfunction

  // Apply one input word to the predicted state and return its result word
  function automatic iesst_pkg::res_t timer_step(logic [1:0] cmd, logic [2:0] code,
                                                 logic [31:0] dur);
    iesst_pkg::res_t r;
    logic flag;
    case (cmd)
      iesst_pkg::CMD_TICK: begin
        tick_ms();
        flag = chg;
      end
      iesst_pkg::CMD_INTERACT: begin
        touch_ms = clock_ms;
        if (cur_code == iesst_pkg::ST_SLEEPING || cur_code == iesst_pkg::ST_CURIOUS ||
            cur_code == iesst_pkg::ST_BORED) begin
          enter_state(iesst_pkg::ST_NORMAL);
        end
        flag = chg;
      end
      iesst_pkg::CMD_SET: begin
        enter_state(code);
        if (dur != '0) begin
          due_ms    = clock_ms + dur;
          due_armed = 1'b1;
        end
        flag = chg;
      end
      default: begin
        flag = chg;
        chg  = 1'b0;
      end
    endcase
    r.current_state = cur_code;
    r.prior_state   = prev_code;
    r.changed_flag  = flag;
    r.timed_active  = due_armed;
    return r;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!idling) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  // Send one word; hold the payload until it is taken
  task automatic send_word(logic [1:0] cmd, logic [2:0] code, logic [31:0] dur);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_new_state   = code;
    in_duration_ms = dur;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(timer_step(cmd, code, dur));
    n_words++;
    n_cmd[cmd]++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three thresholds while the block is idle
  task automatic set_thresholds(logic [31:0] cur_v, logic [31:0] bor_v, logic [31:0] slp_v);
    drain();
    cfg_we    = 1'b1;
    cfg_idx   = iesst_pkg::CFG_CURIOUS;
    cfg_wdata = cur_v;
    @(negedge clk);
    cfg_idx   = iesst_pkg::CFG_BORED;
    cfg_wdata = bor_v;
    @(negedge clk);
    cfg_idx   = iesst_pkg::CFG_SLEEPING;
    cfg_wdata = slp_v;
    @(negedge clk);
    cfg_we    = 1'b0;
    thr.curious  = cur_v;
    thr.bored    = bor_v;
    thr.sleeping = slp_v;
    n_settings++;
  endtask

  // Flag after reset reads set once, then clear
  task automatic test_reset_state();
    send_word(iesst_pkg::CMD_TAKE, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_TAKE, 3'd7, 32'hFFFF_FFFF);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
  endtask

  // Climb curious, bored, sleeping; wake; fall back when thresholds rise
  task automatic test_escalation();
    set_thresholds(32'd2, 32'd4, 32'd6);
    repeat (8) send_word(iesst_pkg::CMD_TICK, 3'd5, 32'h5A5A_A5A5);
    send_word(iesst_pkg::CMD_INTERACT, 3'd7, 32'hFFFF_FFFF);
    send_word(iesst_pkg::CMD_TAKE, 3'd0, 32'd0);
    repeat (4) send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    set_thresholds(32'd10, 32'd20, 32'd30);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
  endtask

  // Timed reactions: expiry, far deadline, deadline wrapped to zero
  task automatic test_timed_states();
    send_word(iesst_pkg::CMD_SET, 3'd5, 32'd3);
    repeat (3) send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_SET, 3'd6, 32'hFFFF_FFFF);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_SET, 3'd7, 32'h8000_0000);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_SET, 3'd7, 32'd0);
    send_word(iesst_pkg::CMD_INTERACT, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_SET, 3'd4, 32'd0 - clock_ms);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_SET, iesst_pkg::ST_BORED, 32'd0);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_TAKE, 3'd0, 32'd0);
  endtask

  // All-zero and all-max thresholds
  task automatic test_threshold_extremes();
    set_thresholds(32'd0, 32'd0, 32'd0);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_INTERACT, 3'd0, 32'd0);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
    set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(iesst_pkg::CMD_SET, iesst_pkg::ST_CURIOUS, 32'd0);
    send_word(iesst_pkg::CMD_TICK, 3'd0, 32'd0);
  endtask

  // Random words: idle runs, interactions, state sets and flag reads
  task automatic random_words(int unsigned count);
    int unsigned k;
    int unsigned p;
    int unsigned burst;
    logic [31:0] dur;
    k = 0;
    while (k < count) begin
      p = $urandom_range(99);
      if (p < 10) begin
        // idle run long enough to climb the escalation
        burst = $urandom_range(40, 8);
        repeat (burst) send_word(iesst_pkg::CMD_TICK, 3'($urandom), 32'($urandom));
        k += burst;
      end else begin
        if (p < 50) begin
          send_word(iesst_pkg::CMD_TICK, 3'($urandom), 32'($urandom));
        end else if (p < 65) begin
          send_word(iesst_pkg::CMD_INTERACT, 3'($urandom), 32'($urandom));
        end else if (p < 82) begin
          p = $urandom_range(99);
          if (p < 30) dur = '0;
          else if (p < 85) dur = 32'($urandom_range(25, 1));
          else dur = 32'($urandom);
          send_word(iesst_pkg::CMD_SET, 3'($urandom), dur);
        end else begin
          send_word(iesst_pkg::CMD_TAKE, 3'($urandom), 32'($urandom));
        end
        k++;
      end
    end
  endtask

  // Random phases under several threshold settings
  task automatic test_random_phases();
    int unsigned ph;
    logic [31:0] c;
    logic [31:0] b;
    for (ph = 0; ph < 6; ph++) begin
      idling = (ph != 3);
      case (ph)
        1: set_thresholds(32'($urandom_range(40)), 32'($urandom_range(40)),
                          32'($urandom_range(40)));
        2: set_thresholds(iesst_pkg::CURIOUS_RST, iesst_pkg::BORED_RST,
                          iesst_pkg::SLEEPING_RST);
        4: set_thresholds(32'd0, 32'hFFFF_FFFF, 32'($urandom_range(30, 10)));
        default: begin
          c = 32'($urandom_range(8, 1));
          b = c + 32'($urandom_range(12, 1));
          set_thresholds(c, b, b + 32'($urandom_range(30, 1)));
        end
      endcase
      random_words(125);
    end
    idling = 1'b1;
  endtask

  // Result stall: random runs, none while idling is off
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(3) == 0) stall_left = pick_gap();
    end
  end

  // Check each taken result word against the oldest prediction
  always @(posedge clk) begin
    iesst_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_current_state !== want.current_state) begin
          $error("current_state: expected %0d, got %0d", want.current_state, out_current_state);
          n_fail++;
        end
        if (out_prior_state !== want.prior_state) begin
          $error("prior_state: expected %0d, got %0d", want.prior_state, out_prior_state);
          n_fail++;
        end
        if (out_changed_flag !== want.changed_flag) begin
          $error("changed_flag: expected %0d, got %0d", want.changed_flag, out_changed_flag);
          n_fail++;
        end
        if (out_timed_active !== want.timed_active) begin
          $error("timed_active: expected %0d, got %0d", want.timed_active, out_timed_active);
          n_fail++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = iesst_pkg::CFG_CURIOUS;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_cmd         = iesst_pkg::CMD_TICK;
    in_new_state   = '0;
    in_duration_ms = '0;
    out_stall      = 1'b0;
    stall_left     = 0;
    idling         = 1'b1;
    n_words        = 0;
    n_checked      = 0;
    n_fail         = 0;
    n_settings     = 0;
    for (int i = 0; i < 4; i++) n_cmd[i] = 0;
    clear_timer();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_escalation();
    test_timed_states();
    test_threshold_extremes();
    test_random_phases();

    // Wait out the last results
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d words: %0d ticks, %0d interactions, %0d state sets, %0d flag reads.",
             n_words, n_cmd[iesst_pkg::CMD_TICK], n_cmd[iesst_pkg::CMD_INTERACT],
             n_cmd[iesst_pkg::CMD_SET], n_cmd[iesst_pkg::CMD_TAKE]);
    $display("Checked %0d result words under %0d threshold settings, %0d mismatches.",
             n_checked, n_settings, n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
